[sv/pvpm_pkg.sv]
// ----------------------------------------------------------------------------
// pvpm_pkg: shared types and constants of the pot value pickup mapper
// Field widths, derived arithmetic widths, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package pvpm_pkg;

    localparam int SAMPLE_BITS = 12;           // ADC code width
    localparam int VAL_BITS    = 16;           // control value width
    localparam int RANGE_BITS  = 12;           // input_range register width
    localparam int EDGE_BITS   = 8;            // input_edges register width

    // sample - edges, signed
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    // max + 1 - min, signed
    localparam int OSPAN_BITS  = VAL_BITS + 2;
    // input_range - 2 * input_edges, signed
    localparam int SPAN_BITS   = RANGE_BITS + 2;
    // |diff| * |outspan| stays below 2^(SAMPLE_BITS + 16)
    localparam int MAG_BITS    = SAMPLE_BITS + VAL_BITS;
    // signed quotient plus min_value
    localparam int SUM_BITS    = MAG_BITS + 2;
    localparam int CNT_BITS    = $clog2(MAG_BITS);

    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = VAL_BITS;
    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + VAL_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = ((VAL_BITS + 2 + 7) / 8) * 8;

    localparam logic signed [VAL_BITS-1:0] MIN_RST   = 16'sd0;
    localparam logic signed [VAL_BITS-1:0] MAX_RST   = 16'sd1023;
    localparam logic [RANGE_BITS-1:0]      RANGE_RST = 12'd1023;
    localparam logic [EDGE_BITS-1:0]       EDGES_RST = 8'd5;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_MIN_VALUE   = 3'd0,
        CFG_MAX_VALUE   = 3'd1,
        CFG_PICKUP_MODE = 3'd2,
        CFG_INPUT_RANGE = 3'd3,
        CFG_INPUT_EDGES = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIX,
        ST_MAP
    } t_state;

endpackage

[sv/pot_value_pickup_mapper_top.sv]
// ----------------------------------------------------------------------------
// pot_value_pickup_mapper_top: potentiometer mapper with soft takeover
// Maps each ADC sample onto [min_value, max_value] through one shared
// multiplier and a bit-serial divider, and tracks pickup of the stored value.
// ----------------------------------------------------------------------------
//
//  channel   direction  signals                        contents
//  s_axis    in         tvalid/tready/tdata/tuser      one sample word (+ optional set)
//  m_axis    out        tvalid/tready/tdata            value, changed, active
//  cfg       in         cfg_we/cfg_addr/cfg_wdata      min, max, pickup, range, edges
//
//  A sample mapping runs one multiply step, MAG_BITS (28) divider steps
//  at one quotient bit per cycle, one fix-up step for sign, offset and clamp,
//  and one update step. The next word is taken only after the update step
//  of the last one; a word in pickup mode, control not yet following, maps the
//  previous sample too. Input is ready only in idle; a full output register
//  holds the update step until it drains. Synchronous active-low reset
//  restores the register defaults and clears stored value, follow flag and
//  previous sample.
//
module pot_value_pickup_mapper_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // s_axis: tdata = sample[11:0], new_value[27:12], reset_pickup[28], zeros
    input  logic                                   i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  logic [pvpm_pkg::IN_TDATA_BITS-1:0]     i_s_axis_tdata,
    // s_axis: tuser = kind[0]
    input  logic                                   i_s_axis_tuser,
    // m_axis: tdata = value[15:0], changed[16], active[17], zeros
    output logic                                   o_m_axis_tvalid,
    input  logic                                   i_m_axis_tready,
    output logic [pvpm_pkg::OUT_TDATA_BITS-1:0]    o_m_axis_tdata,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [pvpm_pkg::CFG_ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [pvpm_pkg::CFG_DATA_BITS-1:0]     i_cfg_wdata
);

    localparam int SB = pvpm_pkg::SAMPLE_BITS;
    localparam int VB = pvpm_pkg::VAL_BITS;
    localparam int RB = pvpm_pkg::RANGE_BITS;
    localparam int EB = pvpm_pkg::EDGE_BITS;
    localparam int DB = pvpm_pkg::DIFF_BITS;
    localparam int OB = pvpm_pkg::OSPAN_BITS;
    localparam int PB = pvpm_pkg::SPAN_BITS;
    localparam int MB = pvpm_pkg::MAG_BITS;
    localparam int XB = pvpm_pkg::SUM_BITS;
    localparam int CB = pvpm_pkg::CNT_BITS;

    // clamp a wide signed value to [min, max], low limit checked first
    function automatic logic signed [VB-1:0] clamp_val(
        input logic signed [XB-1:0] v,
        input logic signed [VB-1:0] lo,
        input logic signed [VB-1:0] hi
    );
        logic signed [XB-1:0] lo_x;
        logic signed [XB-1:0] hi_x;
        lo_x = XB'(lo);
        hi_x = XB'(hi);
        if (v < lo_x) begin
            return lo;
        end else if (v > hi_x) begin
            return hi;
        end
        return v[VB-1:0];
    endfunction

    // ---------------- configuration registers ----------------
    logic signed [VB-1:0] r_min_value;
    logic signed [VB-1:0] r_max_value;
    logic                 r_pickup_mode;
    logic [RB-1:0]        r_input_range;
    logic [EB-1:0]        r_input_edges;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_value   <= pvpm_pkg::MIN_RST;
            r_max_value   <= pvpm_pkg::MAX_RST;
            r_pickup_mode <= 1'b0;
            r_input_range <= pvpm_pkg::RANGE_RST;
            r_input_edges <= pvpm_pkg::EDGES_RST;
        end else if (i_cfg_we) begin
            unique case (pvpm_pkg::t_cfg_idx'(i_cfg_addr))
                pvpm_pkg::CFG_MIN_VALUE:   r_min_value   <= i_cfg_wdata;
                pvpm_pkg::CFG_MAX_VALUE:   r_max_value   <= i_cfg_wdata;
                pvpm_pkg::CFG_PICKUP_MODE: r_pickup_mode <= i_cfg_wdata[0];
                pvpm_pkg::CFG_INPUT_RANGE: r_input_range <= i_cfg_wdata[RB-1:0];
                pvpm_pkg::CFG_INPUT_EDGES: r_input_edges <= i_cfg_wdata[EB-1:0];
                default: ;  // unknown index: drop the write
            endcase
        end
    end

    // ---------------- input unpack ----------------
    logic [SB-1:0]        w_in_sample;
    logic signed [VB-1:0] w_in_new_value;
    logic                 w_in_reset_pickup;
    logic                 w_in_kind;

    assign w_in_sample       = i_s_axis_tdata[SB-1:0];
    assign w_in_new_value    = i_s_axis_tdata[SB+VB-1:SB];
    assign w_in_reset_pickup = i_s_axis_tdata[SB+VB];
    assign w_in_kind         = i_s_axis_tuser;

    // ---------------- sequencer ----------------
    pvpm_pkg::t_state r_state;
    pvpm_pkg::t_state n_state;

    logic w_accept;
    logic w_commit;     // final update cycle writes state and output register
    logic r_prev_pass;  // current mapping is the previous sample

    logic [CB-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pvpm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_commit        = 1'b0;
        unique case (r_state)
            pvpm_pkg::ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = pvpm_pkg::ST_MUL;
                end
            end
            pvpm_pkg::ST_MUL: begin
                n_state = pvpm_pkg::ST_DIV;
            end
            pvpm_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = pvpm_pkg::ST_FIX;
                end
            end
            pvpm_pkg::ST_FIX: begin
                n_state = pvpm_pkg::ST_MAP;
            end
            pvpm_pkg::ST_MAP: begin
                if (r_prev_pass) begin
                    n_state = pvpm_pkg::ST_MUL;
                end else if (!o_m_axis_tvalid || i_m_axis_tready) begin
                    w_commit = 1'b1;
                    n_state  = pvpm_pkg::ST_IDLE;
                end
            end
            default: n_state = pvpm_pkg::ST_IDLE;
        endcase
    end

    assign w_accept = o_s_axis_tready && i_s_axis_tvalid;

    // ---------------- item registers and control state ----------------
    logic [SB-1:0]        r_sample;
    logic [SB-1:0]        r_prev_sample;
    logic signed [VB-1:0] r_stored;
    logic                 r_follow;
    logic signed [VB-1:0] r_map_a;     // mapped previous sample
    logic signed [VB-1:0] r_map;       // result of the latest mapping

    // set path on accept: clamp the new value, drop follow on request
    logic                 w_follow_set;
    logic signed [VB-1:0] w_set_value;

    assign w_follow_set = r_follow &&
                          !(w_in_kind && w_in_reset_pickup && r_pickup_mode);
    assign w_set_value  = clamp_val(XB'(w_in_new_value), r_min_value, r_max_value);

    // update decision in the final cycle
    logic                 w_cross;
    logic                 w_follow_n;
    logic                 w_use;
    logic                 w_changed;

    assign w_cross    = ((r_map_a < r_stored) && (r_map >= r_stored)) ||
                        ((r_map_a > r_stored) && (r_map <= r_stored));
    assign w_follow_n = r_follow || (r_pickup_mode && w_cross);
    assign w_use      = w_follow_n || !r_pickup_mode;
    assign w_changed  = w_use && (r_map != r_stored);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stored      <= '0;
            r_follow      <= 1'b0;
            r_prev_sample <= '0;
            r_prev_pass   <= 1'b0;
        end else if (w_accept) begin
            r_sample    <= w_in_sample;
            r_follow    <= w_follow_set;
            // map the previous sample first only while waiting for pickup
            r_prev_pass <= r_pickup_mode && !w_follow_set;
            if (w_in_kind) begin
                r_stored <= w_set_value;
            end
        end else if (r_state == pvpm_pkg::ST_MAP && r_prev_pass) begin
            r_map_a     <= r_map;
            r_prev_pass <= 1'b0;
        end else if (w_commit) begin
            r_follow      <= w_follow_n;
            r_prev_sample <= r_sample;
            if (w_changed) begin
                r_stored <= r_map;
            end
        end
    end

    // ---------------- shared multiply / divide unit ----------------
    logic [SB-1:0]            w_sel;
    logic signed [DB-1:0]     w_diff;
    logic signed [OB-1:0]     w_ospan;
    logic signed [DB-1:0]     w_diff_neg;
    logic signed [OB-1:0]     w_ospan_neg;
    logic [SB-1:0]            w_diff_mag;
    logic [OB-2:0]            w_ospan_mag;
    logic [SB+OB-2:0]         w_prod;
    logic signed [PB-1:0]     w_span;
    logic                     w_span_pos;
    logic [RB-1:0]            w_span_u;
    logic [RB:0]              w_shift;
    logic [RB:0]              w_sub;
    logic                     w_ge;

    logic [MB-1:0]            r_dvd;   // dividend, shifts into quotient
    logic [RB-1:0]            r_rem;
    logic                     r_neg;

    assign w_sel       = r_prev_pass ? r_prev_sample : r_sample;
    assign w_diff      = $signed({1'b0, w_sel}) -
                         $signed({{(DB-EB){1'b0}}, r_input_edges});
    assign w_ospan     = OB'(r_max_value) + OB'(1) - OB'(r_min_value);
    assign w_diff_neg  = -w_diff;
    assign w_ospan_neg = -w_ospan;
    assign w_diff_mag  = w_diff[DB-1] ? w_diff_neg[SB-1:0] : w_diff[SB-1:0];
    assign w_ospan_mag = w_ospan[OB-1] ? w_ospan_neg[OB-2:0] : w_ospan[OB-2:0];
    assign w_prod      = w_diff_mag * w_ospan_mag;

    assign w_span      = $signed({2'b00, r_input_range}) -
                         $signed({{(PB-EB-1){1'b0}}, r_input_edges, 1'b0});
    assign w_span_pos  = !w_span[PB-1] && (w_span != '0);
    assign w_span_u    = w_span[RB-1:0];

    assign w_shift     = {r_rem, r_dvd[MB-1]};
    assign w_ge        = w_shift >= {1'b0, w_span_u};
    assign w_sub       = w_shift - {1'b0, w_span_u};

    // fix-up: sign, offset, empty window, clamp
    logic signed [XB-1:0] w_q;
    logic signed [XB-1:0] w_qs;
    logic signed [XB-1:0] w_v;

    assign w_q  = $signed({2'b00, r_dvd});
    assign w_qs = r_neg ? -w_q : w_q;
    assign w_v  = w_span_pos ? (w_qs + XB'(r_min_value)) : XB'(r_min_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            unique case (r_state)
                pvpm_pkg::ST_MUL: begin
                    r_cnt <= CB'(MB - 1);
                end
                pvpm_pkg::ST_DIV: begin
                    r_cnt <= r_cnt - CB'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pvpm_pkg::ST_MUL: begin
                // magnitude product, bounded below 2^MAG_BITS
                r_dvd <= w_prod[MB-1:0];
                r_neg <= w_diff[DB-1] ^ w_ospan[OB-1];
                r_rem <= '0;
            end
            pvpm_pkg::ST_DIV: begin
                // one restoring step: one quotient bit
                r_rem <= w_ge ? w_sub[RB-1:0] : w_shift[RB-1:0];
                r_dvd <= {r_dvd[MB-2:0], w_ge};
            end
            pvpm_pkg::ST_FIX: begin
                r_map <= clamp_val(w_v, r_min_value, r_max_value);
            end
            default: ;
        endcase
    end

    // ---------------- output register ----------------
    logic signed [VB-1:0] r_out_value;
    logic                 r_out_changed;
    logic                 r_out_active;
    logic                 r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_value   <= w_changed ? r_map : r_stored;
            r_out_changed <= w_changed;
            r_out_active  <= w_use;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(pvpm_pkg::OUT_TDATA_BITS-VB-2){1'b0}},
                              r_out_active, r_out_changed, r_out_value};

    // ---------------- assertions ----------------
    a_accept_starts_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == pvpm_pkg::ST_MUL))
        else $error("accepted word did not start the multiply step");

    a_mul_loads_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvpm_pkg::ST_MUL) |=>
            (r_state == pvpm_pkg::ST_DIV) && (r_cnt == CB'(MB - 1)))
        else $error("divider not started with full step count");

    a_prev_pass_loops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pvpm_pkg::ST_MAP && r_prev_pass) |=>
            (r_state == pvpm_pkg::ST_MUL) && !r_prev_pass)
        else $error("previous-sample pass did not return for the current sample");

    a_out_from_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state == pvpm_pkg::ST_MAP))
        else $error("result appeared outside the update step");

endmodule
